// ===== sv/dwarf_abbrev_stream_parser_assert.svh =====
// Assertion macros used by the checker file of the abbreviation parser.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef DWARF_ABBREV_STREAM_PARSER_ASSERT_SVH
`define DWARF_ABBREV_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication.
`define DASP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DASP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dasp_pkg.sv =====
// ----------------------------------------------------------------------------
// dasp_pkg
// Types and constants of the abbreviation stream parser: request and record
// payloads, the classified byte token and the record kind codes.
// ----------------------------------------------------------------------------
package dasp_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] IMPLICIT_FORM_RESET = 16'd33;

	localparam logic [1:0] KIND_HEADER    = 2'd0;
	localparam logic [1:0] KIND_ATTR      = 2'd1;
	localparam logic [1:0] KIND_ABBR_END  = 2'd2;
	localparam logic [1:0] KIND_TABLE_END = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       table_start;
	} dasp_req_t;

	typedef struct packed {
		logic [1:0]         record_kind;
		logic [31:0]        abbrev_id;
		logic [15:0]        tag_code;
		logic [7:0]         child_flag;
		logic [15:0]        attr_name;
		logic [15:0]        attr_form;
		logic signed [63:0] implicit_value;
		logic [7:0]         attr_count;
		logic               overlong;
	} dasp_rec_t;

	// Byte as the back end sees it: raw byte, continuation flag, start mark.
	typedef struct packed {
		logic [7:0] raw;
		logic       more;
		logic       start;
	} dasp_tok_t;

	typedef struct packed {
		logic      valid;
		dasp_tok_t tok;
	} dasp_head_t;

endpackage

// ===== sv/dwarf_abbrev_stream_parser.sv =====
// ----------------------------------------------------------------------------
// dwarf_abbrev_stream_parser
// Streaming decoder for an abbreviation table section: bytes in, header,
// attribute, abbrev-end and table-end records out.
// ----------------------------------------------------------------------------
// The block takes one section byte per request and sustains one byte per
// cycle while the record register is not stalled. A byte is queued by the
// front end in a two-entry FIFO and parsed by the back end from its head; a
// record caused by that byte is registered as the byte is parsed and is then
// offered on the rec channel. The parse loop (one LEB byte folded into a
// 64-bit accumulator per cycle) sets that rate. Bytes that end no value give
// no record. While the record register is stalled the parser holds, and the
// FIFO takes up to two more bytes before byte_stall rises.
// Set table_start on the first byte of a table; after a table-end record all
// bytes are dropped until the next table_start. implicit_form_code is written
// through the cfg channel (always ready) and must only change while idle.
// ----------------------------------------------------------------------------
module dwarf_abbrev_stream_parser #(
	parameter int MAX_ATTRS = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	// Byte requests
	input  logic                byte_valid,
	output logic                byte_stall,
	input  dasp_pkg::dasp_req_t byte_req,
	// Records
	output logic                rec_valid,
	input  logic                rec_stall,
	output dasp_pkg::dasp_rec_t rec,
	// Configuration write: implicit_form_code
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import dasp_pkg::*;

	dasp_head_t  head;
	logic        pop;
	logic [15:0] implicit_form_q;

	// Take config writes at any time; the user keeps them to idle periods.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			implicit_form_q <= IMPLICIT_FORM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			implicit_form_q <= cfg_data;
		end
	end

	// Front end: accept and classify bytes, buffer them.
	dasp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_req   (byte_req),
		.head       (head),
		.pop        (pop)
	);

	// Back end: decode LEB values, advance the entry phase, hold the record.
	dasp_back #(
		.MAX_ATTRS (MAX_ATTRS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.head               (head),
		.pop                (pop),
		.implicit_form_code (implicit_form_q),
		.rec_valid          (rec_valid),
		.rec_stall          (rec_stall),
		.rec                (rec)
	);

endmodule

// ===== sv/dasp_front.sv =====
// ----------------------------------------------------------------------------
// dasp_front
// Accept section bytes, tag the LEB continuation bit and queue them for the
// parser in a short FIFO.
// ----------------------------------------------------------------------------
module dasp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  dasp_pkg::dasp_req_t byte_req,
	output dasp_pkg::dasp_head_t head,
	input  logic                pop
);
	import dasp_pkg::*;

	dasp_tok_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               push;
	logic               do_pop;
	dasp_tok_t          tok;

	assign byte_stall = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = byte_valid && !byte_stall;
	assign do_pop     = pop && (cnt_q != '0);

	// Classify the incoming byte.
	assign tok.raw   = byte_req.data_byte;
	assign tok.more  = byte_req.data_byte[7];
	assign tok.start = byte_req.table_start;

	assign head.valid = (cnt_q != '0);
	assign head.tok   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/dasp_back.sv =====
// ----------------------------------------------------------------------------
// dasp_back
// Parser proper: unless stalled, fold one queued byte a cycle into the LEB
// accumulator, walk entry phases and hold each record in an output register.
// ----------------------------------------------------------------------------
module dasp_back #(
	parameter int MAX_ATTRS = 255
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dasp_pkg::dasp_head_t head,
	output logic                 pop,
	input  logic [15:0]          implicit_form_code,
	output logic                 rec_valid,
	input  logic                 rec_stall,
	output dasp_pkg::dasp_rec_t  rec
);
	import dasp_pkg::*;

	localparam int          CAP_I = (MAX_ATTRS < 255) ? MAX_ATTRS : 255;
	localparam logic [7:0]  CAP   = CAP_I[7:0];

	typedef enum logic [2:0] {
		PH_NUMBER,
		PH_TAG,
		PH_CHILDREN,
		PH_NAME,
		PH_FORM,
		PH_CONST
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [63:0] acc_q, acc_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [31:0] num_q, num_d;
	logic [15:0] tag_q, tag_d;
	logic [15:0] name_q, name_d;
	logic [15:0] form_q, form_d;
	logic [7:0]  pairs_q, pairs_d;
	logic        done_q, done_d;
	logic        ovl_q, ovl_d;
	logic        rec_valid_q;
	dasp_rec_t   rec_q;
	logic        emit;
	dasp_rec_t   er;

	assign pop       = head.valid && (!rec_valid_q || !rec_stall);
	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;

	always_comb begin
		logic [6:0]  shamt;
		logic [63:0] v;
		logic        fin;
		logic [63:0] fval;

		ph_d    = ph_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		num_d   = num_q;
		tag_d   = tag_q;
		name_d  = name_q;
		form_d  = form_q;
		pairs_d = pairs_q;
		done_d  = done_q;
		ovl_d   = ovl_q;
		emit    = 1'b0;
		er      = '0;
		fin     = 1'b0;
		fval    = '1;
		v       = '0;
		shamt   = '0;

		// Start of a new table: drop any partial entry.
		if (head.tok.start) begin
			ph_d    = PH_NUMBER;
			acc_d   = '0;
			cnt_d   = '0;
			num_d   = '0;
			tag_d   = '0;
			name_d  = '0;
			form_d  = '0;
			pairs_d = '0;
			done_d  = 1'b0;
			ovl_d   = 1'b0;
		end

		if (!done_d) begin
			if (ph_d == PH_CHILDREN) begin
				emit           = 1'b1;
				er.record_kind = KIND_HEADER;
				er.abbrev_id   = num_d;
				er.tag_code    = tag_d;
				er.child_flag  = head.tok.raw;
				pairs_d        = '0;
				ph_d           = PH_NAME;
			end else begin
				shamt = 7'({cnt_d, 3'b000}) - 7'(cnt_d);
				if (cnt_d < 4'd9) begin
					acc_d = acc_d | ({57'd0, head.tok.raw[6:0]} << shamt[5:0]);
					cnt_d = cnt_d + 4'd1;
				end else if (cnt_d == 4'd9) begin
					acc_d[63] = acc_d[63] | head.tok.raw[0];
					cnt_d     = 4'd10;
				end else begin
					ovl_d = 1'b1;
				end

				if (!head.tok.more) begin
					v     = acc_d;
					acc_d = '0;
					case (ph_d)
						PH_NUMBER: begin
							cnt_d = '0;
							num_d = v[31:0];
							if (v[31:0] == 32'd0) begin
								emit           = 1'b1;
								er.record_kind = KIND_TABLE_END;
								done_d         = 1'b1;
							end else begin
								ph_d = PH_TAG;
							end
						end
						PH_TAG: begin
							cnt_d = '0;
							tag_d = v[15:0];
							ph_d  = PH_CHILDREN;
						end
						PH_NAME: begin
							cnt_d  = '0;
							name_d = v[15:0];
							ph_d   = PH_FORM;
						end
						PH_FORM: begin
							cnt_d  = '0;
							form_d = v[15:0];
							if (v[15:0] == implicit_form_code) begin
								ph_d = PH_CONST;
							end else begin
								fin = 1'b1;
							end
						end
						PH_CONST: begin
							// Sign extend only values shorter than ten bytes.
							shamt = 7'({cnt_d, 3'b000}) - 7'(cnt_d);
							if (cnt_d < 4'd10 && head.tok.raw[6]) begin
								v = v | ({64{1'b1}} << shamt[5:0]);
							end
							cnt_d = '0;
							fval  = v;
							fin   = 1'b1;
						end
						default: begin
							ph_d = PH_NUMBER;
						end
					endcase
				end
			end
		end

		if (fin) begin
			emit         = 1'b1;
			er.abbrev_id = num_d;
			er.tag_code  = tag_d;
			if (name_d == 16'd0) begin
				er.record_kind = KIND_ABBR_END;
				er.attr_count  = pairs_d;
				ph_d           = PH_NUMBER;
			end else begin
				er.record_kind    = KIND_ATTR;
				er.attr_name      = name_d;
				er.attr_form      = form_d;
				er.implicit_value = fval;
				if (pairs_d < CAP) begin
					pairs_d = pairs_d + 8'd1;
				end
				ph_d = PH_NAME;
			end
		end

		// The flag reports overruns since the previous record.
		if (emit) begin
			er.overlong = ovl_d;
			ovl_d       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_NUMBER;
			acc_q       <= '0;
			cnt_q       <= '0;
			num_q       <= '0;
			tag_q       <= '0;
			name_q      <= '0;
			form_q      <= '0;
			pairs_q     <= '0;
			done_q      <= 1'b0;
			ovl_q       <= 1'b0;
			rec_valid_q <= 1'b0;
			rec_q       <= '0;
		end else begin
			if (pop) begin
				ph_q        <= ph_d;
				acc_q       <= acc_d;
				cnt_q       <= cnt_d;
				num_q       <= num_d;
				tag_q       <= tag_d;
				name_q      <= name_d;
				form_q      <= form_d;
				pairs_q     <= pairs_d;
				done_q      <= done_d;
				ovl_q       <= ovl_d;
				rec_valid_q <= emit;
				if (emit) begin
					rec_q <= er;
				end
			end else if (!rec_stall) begin
				rec_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/dasp_checker.sv =====
// ----------------------------------------------------------------------------
// dasp_checker
// Port-level checks of the abbreviation parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "dwarf_abbrev_stream_parser_assert.svh"

module dasp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rec_valid,
	input logic                rec_stall,
	input dasp_pkg::dasp_rec_t rec,
	input logic                cfg_ready
);
	import dasp_pkg::*;

	`DASP_ASSERT_NEXT(a_rec_hold, rec_valid && rec_stall, rec_valid && $stable(rec),
		"stalled record changed")

	`DASP_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "config port not ready")

	`DASP_ASSERT_NOW(a_table_end_clean, rec_valid && rec.record_kind == KIND_TABLE_END,
		rec.abbrev_id == 32'd0 && rec.tag_code == 16'd0 && rec.attr_count == 8'd0,
		"table end carries data")

	`DASP_ASSERT_NOW(a_non_attr_clean, rec_valid && rec.record_kind != KIND_ATTR,
		rec.attr_name == 16'd0 && rec.attr_form == 16'd0 && rec.implicit_value == 64'sd0,
		"attribute fields set outside attribute record")

endmodule

bind dwarf_abbrev_stream_parser dasp_checker u_dasp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rec_valid (rec_valid),
	.rec_stall (rec_stall),
	.rec       (rec),
	.cfg_ready (cfg_ready)
);

// ===== tb/sv/dwarf_abbrev_stream_parser_tb.sv =====
// ----------------------------------------------------------------------------
// dwarf_abbrev_stream_parser_tb
// Feeds abbreviation-section bytes into the parser and predicts every header,
// attribute, abbrev-end and table-end record it should emit.
// Each record that comes out is checked field by field against the prediction.
// ----------------------------------------------------------------------------
module dwarf_abbrev_stream_parser_tb;
	import dasp_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int MAX_ATTRS      = 255;
	localparam int PAIR_CAP       = (MAX_ATTRS < 255) ? MAX_ATTRS : 255;
	localparam int ITEMS_PER_PASS = 30;
	localparam int DRAIN_CYCLES   = 8;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	// Hand-built opening table: two attributes (plain and implicit), a
	// terminating pair that still carries its constant, an all-ones number
	// with a tag wider than 16 bits, an empty abbrev, table end, a dropped byte.
	localparam logic [7:0] PRIMER [24] = '{
		8'h01, 8'h11, 8'h01, 8'h03, 8'h08, 8'h03, 8'h21, 8'h7f,
		8'h00, 8'h21, 8'h40, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f,
		8'hff, 8'hff, 8'h7f, 8'hff, 8'h00, 8'h00, 8'h00, 8'h05
	};

	typedef enum logic [2:0] {
		WANT_NUMBER, WANT_TAG, WANT_CHILDREN, WANT_NAME, WANT_FORM, WANT_CONST
	} parse_st_t;

	// Byte-level parser that mirrors the block, plus the queue of records it
	// has predicted but not yet seen.
	class abbrev_records;
		logic [15:0] form_code;
		parse_st_t   st;
		logic [63:0] acc;
		int unsigned nbytes;
		logic [31:0] number;
		logic [15:0] tag;
		logic [15:0] name;
		logic [15:0] form;
		logic [7:0]  pairs;
		bit          done;
		bit          long_seen;
		dasp_rec_t   queued_recs[$];
		int          errors;

		function new();
			form_code = IMPLICIT_FORM_RESET;
			errors = 0;
			clear();
		endfunction

		function void clear();
			st = WANT_NUMBER;
			acc = '0;
			nbytes = 0;
			number = '0;
			tag = '0;
			name = '0;
			form = '0;
			pairs = '0;
			done = 0;
			long_seen = 0;
		endfunction

		function void set_form_code(logic [15:0] c);
			form_code = c;
		endfunction

		function void post(logic [1:0] kind, logic [31:0] num, logic [15:0] tg,
				logic [7:0] ch, logic [15:0] nm, logic [15:0] fm, logic [63:0] val,
				logic [7:0] cnt);
			dasp_rec_t r;
			r.record_kind    = kind;
			r.abbrev_id      = num;
			r.tag_code       = tg;
			r.child_flag     = ch;
			r.attr_name      = nm;
			r.attr_form      = fm;
			r.implicit_value = val;
			r.attr_count     = cnt;
			r.overlong       = long_seen;
			long_seen = 0;
			queued_recs.push_back(r);
		endfunction

		// Fold one byte into the LEB value; true when the value is complete.
		function bit fold(logic [7:0] b);
			if (nbytes < 9) begin
				acc |= 64'(b[6:0]) << (7 * nbytes);
				nbytes++;
			end else if (nbytes == 9) begin
				acc[63] = acc[63] | b[0];
				nbytes++;
			end else begin
				long_seen = 1;
			end
			return !b[7];
		endfunction

		function void end_pair(logic [63:0] val);
			if (name == 0) begin
				post(KIND_ABBR_END, number, tag, '0, '0, '0, '0, pairs);
				st = WANT_NUMBER;
			end else begin
				post(KIND_ATTR, number, tag, '0, name, form, val, '0);
				if (pairs < PAIR_CAP)
					pairs++;
				st = WANT_NAME;
			end
		endfunction

		function void parse_byte(dasp_req_t r);
			logic [63:0] v;
			if (r.table_start)
				clear();
			if (done)
				return;
			if (st == WANT_CHILDREN) begin
				post(KIND_HEADER, number, tag, r.data_byte, '0, '0, '0, '0);
				pairs = '0;
				st = WANT_NAME;
				return;
			end
			if (!fold(r.data_byte))
				return;
			v = acc;
			acc = '0;
			case (st)
				WANT_NUMBER: begin
					nbytes = 0;
					number = v[31:0];
					if (number == 0) begin
						post(KIND_TABLE_END, '0, '0, '0, '0, '0, '0, '0);
						done = 1;
					end else begin
						st = WANT_TAG;
					end
				end
				WANT_TAG: begin
					nbytes = 0;
					tag = v[15:0];
					st = WANT_CHILDREN;
				end
				WANT_NAME: begin
					nbytes = 0;
					name = v[15:0];
					st = WANT_FORM;
				end
				WANT_FORM: begin
					nbytes = 0;
					form = v[15:0];
					if (form == form_code)
						st = WANT_CONST;
					else
						end_pair('1);
				end
				default: begin
					// sign extend only a constant that ended within ten bytes
					if (nbytes < 10 && r.data_byte[6])
						v |= ~64'd0 << (7 * nbytes);
					nbytes = 0;
					end_pair(v);
				end
			endcase
		endfunction

		function void check_field(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_record(dasp_rec_t got);
			dasp_rec_t want;
			if (queued_recs.size() == 0) begin
				$error("record of kind %0d with nothing predicted", got.record_kind);
				errors++;
				return;
			end
			want = queued_recs.pop_front();
			check_field("record_kind", want.record_kind, got.record_kind);
			check_field("abbrev_id", want.abbrev_id, got.abbrev_id);
			check_field("tag_code", want.tag_code, got.tag_code);
			check_field("child_flag", want.child_flag, got.child_flag);
			check_field("attr_name", want.attr_name, got.attr_name);
			check_field("attr_form", want.attr_form, got.attr_form);
			check_field("implicit_value", want.implicit_value, got.implicit_value);
			check_field("attr_count", want.attr_count, got.attr_count);
			check_field("overlong", want.overlong, got.overlong);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	dasp_req_t   byte_req = '0;
	logic        rec_valid;
	logic        rec_stall = 1'b0;
	dasp_rec_t   rec;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	abbrev_records records;
	dasp_req_t     section_q[$];
	bit            open_section = 0;
	logic [15:0]   cur_code = IMPLICIT_FORM_RESET;
	int            quiet_cycles = 0;
	logic [11:0]   stall_tick = '0;

	dwarf_abbrev_stream_parser #(
		.MAX_ATTRS(MAX_ATTRS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_req   (byte_req),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec        (rec),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Receiver stall: cycle through four moods in turn - free running, light
	// random stall, heavy random stall and a fixed periodic beat.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 12'd1;
		case (stall_tick[9:8])
			2'd0: rec_stall <= 1'b0;
			2'd1: rec_stall <= ($urandom_range(0, 9) < 3);
			2'd2: rec_stall <= ($urandom_range(0, 9) < 8);
			default: rec_stall <= (stall_tick[2:0] >= 3'd5);
		endcase
	end

	// Monitor: predict on every accepted byte request, check every accepted
	// record, track register writes, and bail out if the handshakes go quiet.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall)
				records.parse_byte(byte_req);
			if (rec_valid && !rec_stall)
				records.check_record(rec);
			if (cfg_valid && cfg_ready)
				records.set_form_code(cfg_data);
			if ((byte_valid && !byte_stall) || (rec_valid && !rec_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$error("no handshake for %0d cycles, %0d records outstanding",
					quiet_cycles, records.queued_recs.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ---- stream building -------------------------------------------------

	function automatic logic [63:0] wide_rand();
		return {$urandom, $urandom};
	endfunction

	// Mostly minimal encodings; some padded, a few padded past ten bytes.
	function automatic int pick_pad();
		int k;
		k = $urandom_range(0, 19);
		if (k < 14)
			return 0;
		if (k < 18)
			return $urandom_range(1, 3);
		return $urandom_range(6, 12);
	endfunction

	function automatic logic [63:0] pick_code();
		case ($urandom_range(0, 3))
			0: return 64'($urandom_range(1, 127));
			1: return 64'($urandom_range(128, 65535));
			2: return {32'h0, $urandom};
			default: return wide_rand();
		endcase
	endfunction

	function automatic logic [63:0] pick_form();
		logic [63:0] v;
		if ($urandom_range(0, 2) == 0) begin
			v = 64'(cur_code);
			// same low 16 bits, junk above: still implicit after truncation
			if ($urandom_range(0, 3) == 0)
				v[47:16] = $urandom;
			return v;
		end
		return pick_code();
	endfunction

	// Mark the first byte of a section with table_start.
	function automatic void push_byte(logic [7:0] b);
		dasp_req_t r;
		r.data_byte = b;
		r.table_start = open_section;
		open_section = 0;
		section_q.push_back(r);
	endfunction

	function automatic void put_uleb(logic [63:0] v, int pad);
		logic [6:0] g;
		bit         last;
		do begin
			g = v[6:0];
			v = v >> 7;
			last = (v == 0);
			push_byte({!(last && pad == 0), g});
		end while (!last);
		for (int i = 0; i < pad; i++)
			push_byte((i == pad - 1) ? 8'h00 : 8'h80);
	endfunction

	function automatic void put_raw_leb(int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			b[7] = (i != len - 1);
			push_byte(b);
		end
	endfunction

	function automatic void put_const();
		logic signed [63:0] v;
		logic [6:0]         g;
		bit                 last;
		case ($urandom_range(0, 5))
			0: v = -64'sd1 * $urandom_range(1, 200);
			1: v = 64'($urandom_range(0, 200));
			2: v = wide_rand();
			3: v = $urandom_range(0, 1) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			4: begin
				put_raw_leb($urandom_range(1, 4));
				return;
			end
			default: begin
				put_raw_leb($urandom_range(9, 13));
				return;
			end
		endcase
		do begin
			g = v[6:0];
			v = v >>> 7;
			last = (v == 0 && !g[6]) || (v == -1 && g[6]);
			push_byte({!last, g});
		end while (!last);
	endfunction

	// One abbrev: number, tag, children byte, pairs, terminating pair.
	// Narrow pairs keep every code to one byte for the long saturating entry.
	function automatic void put_abbrev(int n_pairs, bit narrow);
		logic [63:0] v;
		logic [63:0] fm;
		v = pick_code();
		if (v[31:0] == 0)
			v[0] = 1'b1;
		put_uleb(v, pick_pad());
		put_uleb(pick_code(), pick_pad());
		push_byte(8'($urandom));
		repeat (n_pairs) begin
			v = narrow ? 64'($urandom_range(1, 127)) : pick_code();
			if (v[15:0] == 0)
				v[0] = 1'b1;
			put_uleb(v, narrow ? 0 : pick_pad());
			fm = narrow ? 64'($urandom_range(0, 127)) : pick_form();
			put_uleb(fm, narrow ? 0 : pick_pad());
			if (fm[15:0] == cur_code)
				put_const();
		end
		// terminator name: zero, or zero only after truncation to 16 bits
		v = '0;
		if ($urandom_range(0, 3) == 0) begin
			v = wide_rand();
			v[15:0] = '0;
		end
		put_uleb(v, pick_pad());
		fm = pick_form();
		put_uleb(fm, pick_pad());
		if (fm[15:0] == cur_code)
			put_const();
	endfunction

	// One table: a few abbrevs and a zero number, now and then cut short so
	// that the next table_start lands mid-entry.
	function automatic void put_section();
		logic [63:0] v;
		open_section = 1;
		repeat ($urandom_range(1, 2)) begin
			if ($urandom_range(0, 11) == 0) begin
				put_raw_leb($urandom_range(1, 6));
				repeat ($urandom_range(0, 3))
					push_byte(8'($urandom) | 8'h80);
				return;
			end
			put_abbrev($urandom_range(0, 6), 0);
		end
		v = '0;
		if ($urandom_range(0, 3) == 0)
			v = {$urandom | 32'h1, 32'h0};
		put_uleb(v, pick_pad());
	endfunction

	// ---- drivers ----------------------------------------------------------

	// Drain section_q in bursts; drop valid only across a gap.
	task automatic send_section();
		int burst;
		burst = $urandom_range(1, 40);
		while (section_q.size() != 0) begin
			if (burst == 0) begin
				if ($urandom_range(0, 2) != 0) begin
					byte_valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
				burst = $urandom_range(1, 40);
			end
			byte_req <= section_q.pop_front();
			byte_valid <= 1'b1;
			@(posedge clk);
			while (byte_stall)
				@(posedge clk);
			burst--;
		end
		byte_valid <= 1'b0;
	endtask

	// Hold until every predicted record is back, then let the FIFO settle.
	task automatic wait_drained();
		@(posedge clk);
		while (records.queued_recs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_form_code(logic [15:0] c);
		cfg_data <= c;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_code = c;
	endtask

	// Random tables (with the odd burst of pure noise and some bytes after
	// table end that must be dropped), then send and drain.
	task automatic run_pass(int quota);
		int items;
		int n0;
		items = 0;
		while (items < quota) begin
			n0 = section_q.size();
			if ($urandom_range(0, 9) == 0) begin
				open_section = 1;
				repeat ($urandom_range(1, 20))
					push_byte(8'($urandom));
			end else begin
				put_section();
			end
			items += section_q.size() - n0;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4))
					push_byte(8'($urandom));
		end
		send_section();
		wait_drained();
	endtask

	initial begin
		records = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset value of the implicit code: primer, then one abbrev long
		// enough to saturate the attribute count.
		open_section = 1;
		foreach (PRIMER[i])
			push_byte(PRIMER[i]);
		open_section = 1;
		put_abbrev(258, 1);
		put_uleb('0, 0);
		run_pass(ITEMS_PER_PASS);

		// Advance through the extremes of the code and two random ones.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: write_form_code(16'h0000);
				1: write_form_code(16'hffff);
				2: write_form_code(16'($urandom_range(0, 65535)));
				default: write_form_code(16'($urandom_range(1, 127)));
			endcase
			run_pass(ITEMS_PER_PASS);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (records.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
